### hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked property, disabled while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// clocked property checked during reset too
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hdl/rtpd_pkg.sv
package rtpd_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_AGG    = 2'd2,
    MODE_FRAG   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    AGG_LEN_HI = 2'd0,
    AGG_LEN_LO = 2'd1,
    AGG_DATA   = 2'd2
  } agg_phase_t;

  // one request from front to back: optional start code, optional data byte
  typedef struct packed {
    logic       prefix;
    logic       data;
    logic [7:0] value;
  } cmd_t;

  localparam logic [4:0] TYPE_SINGLE_MIN = 5'd1;
  localparam logic [4:0] TYPE_SINGLE_MAX = 5'd23;
  localparam logic [4:0] TYPE_STAP_A     = 5'd24;
  localparam logic [4:0] TYPE_FU_A       = 5'd28;

  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  localparam logic [1:0] STEP_SC0  = 2'd0;
  localparam logic [1:0] STEP_SC1  = 2'd1;
  localparam logic [1:0] STEP_SC2  = 2'd2;
  localparam logic [1:0] STEP_DATA = 2'd3;

endpackage

### hdl/rtpd_front.sv
module rtpd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     in_byte,
  input  logic           in_first,
  input  logic           in_last,
  output logic           cmd_valid,
  output rtpd_pkg::cmd_t cmd
);

  rtpd_pkg::mode_t      mode_r, mode_nxt;
  rtpd_pkg::agg_phase_t phase_r, phase_nxt;
  logic                 fu_hdr_r, fu_hdr_nxt;
  logic [7:0]           len_hi_r, len_hi_nxt;
  logic [15:0]          left_r, left_nxt;
  logic [2:0]           top_r, top_nxt;

  logic [4:0]  nal_type;
  logic [15:0] len_full;
  logic [15:0] left_dec;

  assign nal_type = in_byte[4:0];
  assign len_full = {len_hi_r, in_byte};
  assign left_dec = left_r - 16'd1;

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    phase_nxt  = phase_r;
    fu_hdr_nxt = fu_hdr_r;
    len_hi_nxt = len_hi_r;
    left_nxt   = left_r;
    top_nxt    = top_r;
    if (accept) begin
      if (in_first) begin
        phase_nxt  = rtpd_pkg::AGG_LEN_HI;
        fu_hdr_nxt = 1'b0;
        len_hi_nxt = 8'h00;
        left_nxt   = 16'd0;
        if (nal_type >= rtpd_pkg::TYPE_SINGLE_MIN && nal_type <= rtpd_pkg::TYPE_SINGLE_MAX) begin
          mode_nxt = rtpd_pkg::MODE_SINGLE;
        end else if (nal_type == rtpd_pkg::TYPE_STAP_A) begin
          mode_nxt = rtpd_pkg::MODE_AGG;
        end else if (nal_type == rtpd_pkg::TYPE_FU_A) begin
          mode_nxt   = rtpd_pkg::MODE_FRAG;
          top_nxt    = in_byte[7:5];
          fu_hdr_nxt = 1'b1;
        end else begin
          mode_nxt = rtpd_pkg::MODE_IDLE;
        end
      end else if (mode_r == rtpd_pkg::MODE_AGG) begin
        unique case (phase_r)
          rtpd_pkg::AGG_LEN_HI: begin
            len_hi_nxt = in_byte;
            phase_nxt  = rtpd_pkg::AGG_LEN_LO;
          end
          rtpd_pkg::AGG_LEN_LO: begin
            left_nxt  = len_full;
            phase_nxt = (len_full == 16'd0) ? rtpd_pkg::AGG_LEN_HI : rtpd_pkg::AGG_DATA;
          end
          default: begin
            left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              phase_nxt = rtpd_pkg::AGG_LEN_HI;
            end
          end
        endcase
      end else if (mode_r == rtpd_pkg::MODE_FRAG) begin
        fu_hdr_nxt = 1'b0;
      end
      // packet end cuts any unfinished unit
      if (in_last) begin
        mode_nxt   = rtpd_pkg::MODE_IDLE;
        fu_hdr_nxt = 1'b0;
        phase_nxt  = rtpd_pkg::AGG_LEN_HI;
        left_nxt   = 16'd0;
      end
    end
  end

  // request toward the back end
  always_comb begin
    cmd.prefix = 1'b0;
    cmd.data   = 1'b0;
    cmd.value  = in_byte;
    if (in_first) begin
      if (nal_type >= rtpd_pkg::TYPE_SINGLE_MIN && nal_type <= rtpd_pkg::TYPE_SINGLE_MAX) begin
        cmd.prefix = 1'b1;
        cmd.data   = 1'b1;
      end
    end else begin
      unique case (mode_r)
        rtpd_pkg::MODE_SINGLE: cmd.data = 1'b1;
        rtpd_pkg::MODE_AGG: begin
          if (phase_r == rtpd_pkg::AGG_LEN_LO) begin
            cmd.prefix = 1'b1;
          end else if (phase_r == rtpd_pkg::AGG_DATA) begin
            cmd.data = 1'b1;
          end
        end
        rtpd_pkg::MODE_FRAG: begin
          if (fu_hdr_r) begin
            // rebuilt nal header on the start fragment only
            cmd.prefix = in_byte[7];
            cmd.data   = in_byte[7];
            cmd.value  = {top_r, in_byte[4:0]};
          end else begin
            cmd.data = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign cmd_valid = accept && (cmd.prefix || cmd.data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= rtpd_pkg::MODE_IDLE;
      phase_r  <= rtpd_pkg::AGG_LEN_HI;
      fu_hdr_r <= 1'b0;
      len_hi_r <= 8'h00;
      left_r   <= 16'd0;
      top_r    <= 3'd0;
    end else begin
      mode_r   <= mode_nxt;
      phase_r  <= phase_nxt;
      fu_hdr_r <= fu_hdr_nxt;
      len_hi_r <= len_hi_nxt;
      left_r   <= left_nxt;
      top_r    <= top_nxt;
    end
  end

endmodule

### hdl/rtpd_cmd_queue.sv
module rtpd_cmd_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rtpd_pkg::cmd_t push_cmd,
  input  logic           pop,
  output rtpd_pkg::cmd_t head_cmd,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rtpd_pkg::cmd_t      slot_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hdl/rtpd_back.sv
module rtpd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_avail,
  input  rtpd_pkg::cmd_t cmd,
  output logic           cmd_done,
  output logic           advance,
  input  logic           out_pop,
  output logic           out_empty,
  output logic [7:0]     out_stream_byte,
  output logic           out_unit_start,
  output logic           out_run_last
);

  logic [1:0] step_r, step_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       start_r;
  logic       last_r;

  logic [7:0] res_byte;
  logic       res_start;
  logic       res_last;

  // expand one request into start code bytes and data byte
  always_comb begin
    res_byte  = cmd.value;
    res_start = 1'b0;
    res_last  = 1'b1;
    if (cmd.prefix && step_r != rtpd_pkg::STEP_DATA) begin
      res_byte  = (step_r == rtpd_pkg::STEP_SC2) ? rtpd_pkg::SC_ONE : rtpd_pkg::SC_ZERO;
      res_start = (step_r == rtpd_pkg::STEP_SC0);
      res_last  = !cmd.data && (step_r == rtpd_pkg::STEP_SC2);
    end
  end

  assign advance   = cmd_avail && (!valid_r || out_pop);
  assign cmd_done  = advance && res_last;
  assign step_nxt  = advance ? (res_last ? rtpd_pkg::STEP_SC0 : step_r + 2'd1) : step_r;
  assign valid_nxt = advance ? 1'b1 : (out_pop ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r  <= res_byte;
      start_r <= res_start;
      last_r  <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= rtpd_pkg::STEP_SC0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_empty       = !valid_r;
  assign out_stream_byte = byte_r;
  assign out_unit_start  = start_r;
  assign out_run_last    = last_r;

endmodule

### hdl/rtp_h264_depacketizer_top.sv
// rtp h.264 depacketizer: rtp payload bytes in, annex b byte stream out
// input queue: in_payload_byte with in_first_of_payload / in_last_of_payload
//   marks, taken at a clock edge where in_push is high and in_full is low
// result queue: out_stream_byte, out_unit_start (first 00 of a start code),
//   out_run_last (last result of one input byte); shown while out_empty is
//   low, taken at an edge where out_pop is high
// the front end classifies each byte (single nal, stap-a, fu-a, drop) and
//   turns it into a request: start code, data byte, or both
// a CMD_DEPTH-entry request queue parts front from back; the back end sends
//   one result byte per cycle into an output register, unless out_pop stalls
// an accepted byte passes the request queue, then the output register
// throughput: one byte per cycle for copied data while results are popped;
//   a request with a start code gives 3 or 4 result bytes, which the request
//   queue absorbs before in_full rises
// reset (rst_n low, synchronous) empties both queues and awaits a new packet
// when the receiver stalls, the output register holds and the request queue
//   fills; in_full then rises until results are popped
module rtp_h264_depacketizer_top #(
  parameter int CMD_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_payload_byte,
  input  logic       in_first_of_payload,
  input  logic       in_last_of_payload,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_stream_byte,
  output logic       out_unit_start,
  output logic       out_run_last
);

  // request handshake on the input side
  logic           in_accept;
  logic           cmd_valid;
  rtpd_pkg::cmd_t cmd_in;
  rtpd_pkg::cmd_t cmd_head;
  logic           q_full;
  logic           q_empty;
  logic           cmd_done;
  logic           back_adv;

  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  // classify bytes and keep packet state
  rtpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .in_byte   (in_payload_byte),
    .in_first  (in_first_of_payload),
    .in_last   (in_last_of_payload),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_in)
  );

  // decoupling queue between classification and emission
  rtpd_cmd_queue #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_valid),
    .push_cmd (cmd_in),
    .pop      (cmd_done),
    .head_cmd (cmd_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // emit start codes and data, one byte per cycle while results are popped
  rtpd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_avail       (!q_empty),
    .cmd             (cmd_head),
    .cmd_done        (cmd_done),
    .advance         (back_adv),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_stream_byte (out_stream_byte),
    .out_unit_start  (out_unit_start),
    .out_run_last    (out_run_last)
  );

`include "assert_macros.svh"

  // a request is only produced when the queue has room
  `ASSERT_CLK(a_no_overflow, clk, rst_n, cmd_valid |-> !q_full)
  // the back end only moves with a request waiting
  `ASSERT_CLK(a_adv_has_cmd, clk, rst_n, back_adv |-> !q_empty)
  // a shown start code begins with a zero byte
  `ASSERT_CLK(a_start_zero, clk, rst_n,
    (!out_empty && out_unit_start) |-> (out_stream_byte == rtpd_pkg::SC_ZERO))
  // reset leaves no result waiting
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> out_empty)

endmodule
